// ===== src/raid5_stripe_parity_encoder_top_assert.svh =====
// Assertion macros for the stripe parity encoder.
`ifndef RAID5_STRIPE_PARITY_ENCODER_TOP_ASSERT_SVH
`define RAID5_STRIPE_PARITY_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define R5SPE_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("r5spe assertion failed");

// Next-cycle implication, disabled during reset.
`define R5SPE_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("r5spe assertion failed");

`endif

// ===== src/r5spe_pkg.sv =====
// Shared constants and types of the stripe parity encoder.
`default_nettype none

package r5spe_pkg;

  localparam int MAX_STRIPE_BYTES_DEF = 4096;
  localparam int MAX_BLOCKS_DEF       = 16;
  localparam int MIN_BLOCKS           = 3;

  localparam int BLOCK_COUNT_W = 5;
  localparam int SEG_LEN_W     = 16;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 2;
  localparam int DATA_W        = 8;
  localparam int BLOCK_W       = 4;
  localparam int OFFSET_W      = 12;
  localparam int STATUS_W      = 2;

  localparam logic [BLOCK_COUNT_W-1:0] BLOCK_COUNT_RST = BLOCK_COUNT_W'(3);
  localparam logic [SEG_LEN_W-1:0]     SEG_LEN_RST     = SEG_LEN_W'(1);

  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_LENGTH = CFG_INDEX_W'(1);

  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK           = 2'd0,
    STATUS_NONE_PENDING = 2'd1,
    STATUS_TOO_LARGE    = 2'd2,
    STATUS_EXCESS       = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ===== src/r5spe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none

module r5spe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/raid5_stripe_parity_encoder_top.sv =====
// Stripe parity encoder: stripes a byte segment over data blocks and builds parity.
// Usage:
//   Configure block_count (index 0) and segment_length (index 1) on the write
//   port while the block is idle. Each write to either register restarts the
//   stream and starts a bit-serial divider that sizes the stripe; input stays
//   stalled through the load and divide states (17-bit dividend).
//   Input requests carry cmd and data with valid/stall; cmd 0 streams a segment
//   byte, cmd 1 drains the next pad byte, then the parity block, then reports
//   nothing pending. Every accepted request yields exactly one result request
//   on the output channel (block_index, offset, value, last, status).
//   Throughput is one request per cycle while neither the output nor the divider
//   stalls it; a result passes through the read stage (parity store read) and
//   then the output register. Store read, XOR and write-back to the same
//   entry in consecutive cycles are covered by a forwarding register.
//   When the output is stalled, one more request is held in the read stage and
//   then input stalls. Reset loads block_count 3 and segment_length 1 and runs
//   the divider; the parity store is not cleared, every entry read is written
//   earlier in the same stream.
`default_nettype none

`include "raid5_stripe_parity_encoder_top_assert.svh"

module raid5_stripe_parity_encoder_top #(
  parameter int MAX_STRIPE_BYTES = r5spe_pkg::MAX_STRIPE_BYTES_DEF,
  parameter int MAX_BLOCKS       = r5spe_pkg::MAX_BLOCKS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [r5spe_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [r5spe_pkg::CFG_DATA_W-1:0]   wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               cmd,
  input  logic [r5spe_pkg::DATA_W-1:0]       data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [r5spe_pkg::BLOCK_W-1:0]      block_index,
  output logic [r5spe_pkg::OFFSET_W-1:0]     offset,
  output logic [r5spe_pkg::DATA_W-1:0]       value,
  output logic                               last,
  output logic [r5spe_pkg::STATUS_W-1:0]     status
);

  import r5spe_pkg::*;

  localparam int AW = $clog2(MAX_STRIPE_BYTES);
  localparam int OW = $clog2(MAX_STRIPE_BYTES + 1);
  localparam int BW = $clog2(MAX_BLOCKS);
  localparam int NW = SEG_LEN_W + 1;
  localparam int CW = $clog2(NW);

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_DIV   = 6'b000010,
    ST_DATA  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_DONE  = 6'b010000,
    ST_ERROR = 6'b100000
  } state_t;

  typedef struct packed {
    logic [BLOCK_W-1:0]  blk;
    logic [OFFSET_W-1:0] off;
    logic [DATA_W-1:0]   data;
    logic                last;
    status_t             status;
    logic                wr_en;
    logic                xor_mode;
    logic                use_parity;
    logic [AW-1:0]       addr;
  } op_t;

  state_t                   state, state_next;
  logic [BLOCK_COUNT_W-1:0] block_count;
  logic [SEG_LEN_W-1:0]     segment_length;
  logic [NW-1:0]            stripe_bytes, stripe_bytes_next;
  logic [BW-1:0]            block_counter, block_counter_next;
  logic [OW-1:0]            offset_counter, offset_counter_next;
  logic [SEG_LEN_W-1:0]     received, received_next;
  logic [NW-1:0]            div_num, div_num_next;
  logic [BW:0]              div_rem, div_rem_next;
  logic [CW-1:0]            div_cnt, div_cnt_next;

  logic [31:0]   eff32, data_blocks32, bc32, off32, off_inc;
  logic [BW-1:0] data_blocks;
  logic [BW:0]   div_shift;
  logic          div_fit, wrap, accept, cfg_hit;

  op_t              op, s1;
  logic             s1_valid, s1_move;
  logic [DATA_W-1:0] ram_q, rd, wdata;
  logic             fwd_valid;
  logic [AW-1:0]    fwd_addr;
  logic [DATA_W-1:0] fwd_data;

  assign cfg_hit = wr_en && (wr_index == REG_BLOCK_COUNT || wr_index == REG_SEGMENT_LENGTH);

  always_comb begin
    if (32'(block_count) < 32'(MIN_BLOCKS)) begin
      eff32 = 32'(MIN_BLOCKS);
    end else if (32'(block_count) > 32'(MAX_BLOCKS)) begin
      eff32 = 32'(MAX_BLOCKS);
    end else begin
      eff32 = 32'(block_count);
    end
    data_blocks32 = eff32 - 32'd1;
    data_blocks   = data_blocks32[BW-1:0];
  end

  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = (state == ST_LOAD) || (state == ST_DIV) || (s1_valid && !s1_move);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next          = state;
    stripe_bytes_next   = stripe_bytes;
    block_counter_next  = block_counter;
    offset_counter_next = offset_counter;
    received_next       = received;
    div_num_next        = div_num;
    div_rem_next        = div_rem;
    div_cnt_next        = div_cnt;
    op                  = '0;
    op.status           = STATUS_OK;
    op.addr             = offset_counter[AW-1:0];
    bc32                = 32'(block_counter);
    off32               = 32'(offset_counter);
    off_inc             = off32 + 32'd1;
    wrap                = off_inc >= 32'(stripe_bytes);
    div_shift           = {div_rem[BW-1:0], div_num[NW-1]};
    div_fit             = div_shift >= {1'b0, data_blocks};

    case (state)
      ST_LOAD: begin
        div_num_next        = NW'(32'(segment_length) + data_blocks32 - 32'd1);
        div_rem_next        = '0;
        div_cnt_next        = '0;
        stripe_bytes_next   = '0;
        block_counter_next  = '0;
        offset_counter_next = '0;
        received_next       = '0;
        state_next          = ST_DIV;
      end
      ST_DIV: begin
        div_rem_next      = div_fit ? div_shift - {1'b0, data_blocks} : div_shift;
        div_num_next      = {div_num[NW-2:0], 1'b0};
        stripe_bytes_next = {stripe_bytes[NW-2:0], div_fit};
        div_cnt_next      = div_cnt + CW'(1);
        if (32'(div_cnt) == NW - 1) begin
          state_next = (32'(stripe_bytes_next) > 32'(MAX_STRIPE_BYTES)) ? ST_ERROR : ST_DATA;
        end
      end
      default: begin
        if (accept) begin
          if (state == ST_ERROR) begin
            op.status = STATUS_TOO_LARGE;
          end else if (cmd == CMD_DATA) begin
            if (state != ST_DATA || received >= segment_length
                || block_counter >= data_blocks) begin
              op.status = STATUS_EXCESS;
            end else begin
              op.wr_en      = 1'b1;
              op.xor_mode   = block_counter != '0;
              op.data       = data;
              op.blk        = bc32[BLOCK_W-1:0];
              op.off        = off32[OFFSET_W-1:0];
              received_next = received + SEG_LEN_W'(1);
              if (wrap) begin
                offset_counter_next = '0;
                block_counter_next  = block_counter + BW'(1);
              end else begin
                offset_counter_next = OW'(off_inc);
              end
            end
          end else if (state == ST_DONE || stripe_bytes == '0) begin
            op.status  = STATUS_NONE_PENDING;
            state_next = ST_DONE;
          end else begin
            state_next = ST_DRAIN;
            op.off     = off32[OFFSET_W-1:0];
            if (block_counter < data_blocks) begin
              op.wr_en = block_counter == '0;
              op.blk   = bc32[BLOCK_W-1:0];
              if (wrap) begin
                offset_counter_next = '0;
                block_counter_next  = block_counter + BW'(1);
              end else begin
                offset_counter_next = OW'(off_inc);
              end
            end else begin
              op.use_parity       = 1'b1;
              op.blk              = data_blocks32[BLOCK_W-1:0];
              op.last             = wrap;
              offset_counter_next = OW'(off_inc);
              if (wrap) begin
                state_next = ST_DONE;
              end
            end
          end
        end
      end
    endcase

    if (cfg_hit) begin
      state_next = ST_LOAD;
    end
  end

  always_comb begin
    rd    = (fwd_valid && fwd_addr == s1.addr) ? fwd_data : ram_q;
    wdata = s1.xor_mode ? (rd ^ s1.data) : s1.data;
  end

  r5spe_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_STRIPE_BYTES)
  ) u_parity_store (
    .clk   (clk),
    .we    (s1_move && s1.wr_en),
    .waddr (s1.addr),
    .wdata (wdata),
    .re    (accept),
    .raddr (op.addr),
    .q     (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_LOAD;
      block_count    <= BLOCK_COUNT_RST;
      segment_length <= SEG_LEN_RST;
      stripe_bytes   <= '0;
      block_counter  <= '0;
      offset_counter <= '0;
      received       <= '0;
      div_num        <= '0;
      div_rem        <= '0;
      div_cnt        <= '0;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      fwd_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      stripe_bytes   <= stripe_bytes_next;
      block_counter  <= block_counter_next;
      offset_counter <= offset_counter_next;
      received       <= received_next;
      div_num        <= div_num_next;
      div_rem        <= div_rem_next;
      div_cnt        <= div_cnt_next;
      if (wr_en && wr_index == REG_BLOCK_COUNT) begin
        block_count <= wr_data[BLOCK_COUNT_W-1:0];
      end
      if (wr_en && wr_index == REG_SEGMENT_LENGTH) begin
        segment_length <= wr_data[SEG_LEN_W-1:0];
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (s1_move && s1.wr_en) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= op;
    end
    if (s1_move && s1.wr_en) begin
      fwd_addr <= s1.addr;
      fwd_data <= wdata;
    end
    if (s1_move) begin
      block_index <= s1.blk;
      offset      <= s1.off;
      value       <= s1.use_parity ? rd : s1.data;
      last        <= s1.last;
      status      <= s1.status;
    end
  end

  `R5SPE_ASSERT_NEXT(a_cfg_restart, clk, rst, cfg_hit, state == ST_LOAD)
  `R5SPE_ASSERT_IMP(a_stall_while_sizing, clk, rst, state == ST_LOAD || state == ST_DIV, in_stall)
  `R5SPE_ASSERT_IMP(a_status_clears_fields, clk, rst, out_valid && status != STATUS_OK, block_index == '0 && offset == '0 && value == '0 && last == 1'b0)
  `R5SPE_ASSERT_IMP(a_received_bound, clk, rst, state == ST_DATA, received <= segment_length)
  `R5SPE_ASSERT_IMP(a_block_bound, clk, rst, state != ST_LOAD && state != ST_DIV, block_counter <= data_blocks)

endmodule

`default_nettype wire

// ===== tb/sv/r5spe_stripe_check.sv =====
// Stripe parity encoder checker: predicts each result from accepted requests and compares.
module r5spe_stripe_check
  import r5spe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic                   cmd,
  input  logic [DATA_W-1:0]      data,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  logic [BLOCK_W-1:0]     block_index,
  input  logic [OFFSET_W-1:0]    offset,
  input  logic [DATA_W-1:0]      value,
  input  logic                   last,
  input  logic [STATUS_W-1:0]    status,
  output int                     outstanding,
  output int                     failures
);

  typedef enum logic [1:0] {
    FILLING,
    DRAINING,
    FINISHED,
    OVERSIZE
  } stream_phase_t;

  typedef struct packed {
    logic [BLOCK_W-1:0]  blk;
    logic [OFFSET_W-1:0] off;
    logic [DATA_W-1:0]   val;
    logic                lst;
    status_t             st;
  } stripe_byte_t;

  logic [BLOCK_COUNT_W-1:0] blocks_cfg;
  logic [SEG_LEN_W-1:0]     seg_len;
  logic [SEG_LEN_W-1:0]     stripe_len;
  logic [BLOCK_W-1:0]       blk_cnt;
  logic [OFFSET_W:0]        off_cnt;
  stream_phase_t            phase_q;
  logic [DATA_W-1:0]        parity_mem [MAX_STRIPE_BYTES_DEF];
  stripe_byte_t             expected_bytes [$];
  int                       mismatch_cnt = 0;

  function automatic logic [BLOCK_W-1:0] data_blocks();
    logic [BLOCK_COUNT_W-1:0] n;
    n = blocks_cfg;
    if (n < MIN_BLOCKS) n = BLOCK_COUNT_W'(MIN_BLOCKS);
    if (n > MAX_BLOCKS_DEF) n = BLOCK_COUNT_W'(MAX_BLOCKS_DEF);
    return BLOCK_W'(n - 1);
  endfunction

  function automatic void restart_stream();
    int unsigned nd;
    int unsigned sb;
    nd = data_blocks();
    sb = (seg_len + nd - 1) / nd;
    stripe_len = SEG_LEN_W'(sb);
    blk_cnt = '0;
    off_cnt = '0;
    phase_q = (sb > MAX_STRIPE_BYTES_DEF) ? OVERSIZE : FILLING;
  endfunction

  function automatic void step_offset();
    off_cnt++;
    if (off_cnt >= stripe_len) begin
      off_cnt = '0;
      blk_cnt++;
    end
  endfunction

  function automatic stripe_byte_t encode_request(logic c, logic [DATA_W-1:0] d_in);
    stripe_byte_t        r;
    logic [BLOCK_W-1:0]  nd;
    logic [OFFSET_W-1:0] idx;
    int unsigned         received;
    r = '0;
    r.st = STATUS_OK;
    nd = data_blocks();
    idx = off_cnt[OFFSET_W-1:0];
    if (phase_q == OVERSIZE) begin
      r.st = STATUS_TOO_LARGE;
      return r;
    end
    if (c == CMD_DATA) begin
      received = blk_cnt * stripe_len + off_cnt;
      if (phase_q != FILLING || received >= seg_len || blk_cnt >= nd) begin
        r.st = STATUS_EXCESS;
        return r;
      end
      parity_mem[idx] = (blk_cnt == 0) ? d_in : (parity_mem[idx] ^ d_in);
      r.blk = blk_cnt;
      r.off = idx;
      r.val = d_in;
      step_offset();
      return r;
    end
    if (phase_q == FINISHED || stripe_len == 0) begin
      phase_q = FINISHED;
      r.st = STATUS_NONE_PENDING;
      return r;
    end
    phase_q = DRAINING;
    if (blk_cnt < nd) begin
      if (blk_cnt == 0) parity_mem[idx] = '0;
      r.blk = blk_cnt;
      r.off = idx;
      step_offset();
      return r;
    end
    r.blk = nd;
    r.off = idx;
    r.val = parity_mem[idx];
    r.lst = (off_cnt + 1 >= stripe_len);
    off_cnt++;
    if (r.lst) phase_q = FINISHED;
    return r;
  endfunction

  function automatic void flag(string what);
    mismatch_cnt++;
    $error("%s", what);
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) flag($sformatf("%s: expected %0d, got %0d", name, want, got));
  endfunction

  always @(posedge clk) begin : watch
    stripe_byte_t want;
    if (rst) begin
      blocks_cfg = BLOCK_COUNT_RST;
      seg_len = SEG_LEN_RST;
      restart_stream();
      expected_bytes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          flag("result with no request waiting");
        end else begin
          want = expected_bytes.pop_front();
          check_field("block_index", 16'(want.blk), 16'(block_index));
          check_field("offset", 16'(want.off), 16'(offset));
          check_field("value", 16'(want.val), 16'(value));
          check_field("last", 16'(want.lst), 16'(last));
          check_field("status", 16'(want.st), 16'(status));
        end
      end
      if (in_valid && !in_stall) begin
        expected_bytes.insert(expected_bytes.size(), encode_request(cmd, data));
      end
      if (wr_en) begin
        case (wr_index)
          REG_BLOCK_COUNT: begin
            blocks_cfg = wr_data[BLOCK_COUNT_W-1:0];
            restart_stream();
          end
          REG_SEGMENT_LENGTH: begin
            seg_len = wr_data[SEG_LEN_W-1:0];
            restart_stream();
          end
          default: ;
        endcase
      end
    end
    outstanding <= expected_bytes.size();
    failures <= mismatch_cnt;
  end

endmodule

// ===== tb/sv/tb.sv =====
// Stripe parity encoder testbench top: clock, reset, request stimulus, result stalls, verdict.
module tb;
  import r5spe_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] wr_index = '0;
  logic [CFG_DATA_W-1:0]  wr_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   cmd = 1'b0;
  logic [DATA_W-1:0]      data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [BLOCK_W-1:0]     block_index;
  logic [OFFSET_W-1:0]    offset;
  logic [DATA_W-1:0]      value;
  logic                   last;
  logic [STATUS_W-1:0]    status;
  int                     outstanding;
  int                     failures;

  logic        hold_req = 1'b0;
  int          burst_left = 0;
  int unsigned stream_items = 0;

  always #5 clk = ~clk;

  raid5_stripe_parity_encoder_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .data        (data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .block_index (block_index),
    .offset      (offset),
    .value       (value),
    .last        (last),
    .status      (status)
  );

  r5spe_stripe_check i_check (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .data        (data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .block_index (block_index),
    .offset      (offset),
    .value       (value),
    .last        (last),
    .status      (status),
    .outstanding (outstanding),
    .failures    (failures)
  );

  task automatic send_req(input logic c, input logic [DATA_W-1:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    cmd <= c;
    data <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  task automatic fill(input int unsigned n);
    repeat (n) begin
      send_req(CMD_DATA, 8'($urandom));
      stream_items++;
    end
  endtask

  task automatic drain(input int unsigned n);
    repeat (n) begin
      send_req(CMD_DRAIN, 8'($urandom));
      stream_items++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic configure(input logic [BLOCK_COUNT_W-1:0] bc, input logic [SEG_LEN_W-1:0] sl);
    logic [CFG_DATA_W-BLOCK_COUNT_W-1:0] hi;
    hi = ($urandom_range(0, 1) == 1) ? (CFG_DATA_W-BLOCK_COUNT_W)'($urandom) : '0;
    wait_drained();
    set_reg(REG_BLOCK_COUNT, {hi, bc});
    set_reg(REG_SEGMENT_LENGTH, sl);
  endtask

  // receiver: stall pattern changes mode now and then; one long hold on request
  initial begin : rx_stall
    int  mode;
    int  mode_left;
    int  hold_left;
    bit  hold_taken;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 120);
        end
        mode_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= (mode_left % 4 == 0);
          default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned              phase_no;
    int unsigned              nd;
    int unsigned              sb;
    int unsigned              k;
    int                       kind;
    logic [BLOCK_COUNT_W-1:0] bc;
    logic [SEG_LEN_W-1:0]     sl;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: one-byte segment, full life cycle
    send_req(CMD_DATA, 8'hFF);
    send_req(CMD_DATA, 8'h00);
    send_req(CMD_DRAIN, 8'h00);
    send_req(CMD_DRAIN, 8'hFF);
    send_req(CMD_DRAIN, 8'h5A);
    send_req(CMD_DATA, 8'h81);

    // clamped block count, empty segment
    configure(5'd0, 16'd0);
    send_req(CMD_DATA, 8'h7E);
    send_req(CMD_DRAIN, 8'h01);
    send_req(CMD_DATA, 8'h80);

    // clamped block count, oversized segment
    configure(5'd31, 16'hFFFF);
    send_req(CMD_DATA, 8'h3C);
    send_req(CMD_DRAIN, 8'hC3);

    // early drain with data offered mid-drain
    configure(5'd5, 16'd7);
    send_req(CMD_DATA, 8'hA5);
    send_req(CMD_DATA, 8'h5A);
    send_req(CMD_DRAIN, 8'h00);
    send_req(CMD_DATA, 8'h33);
    repeat (8) send_req(CMD_DRAIN, 8'hFF);

    phase_no = 0;
    stream_items = 0;
    while (stream_items < 1250) begin
      phase_no++;
      if (phase_no == 4) begin
        bc = 5'd4;
        sl = 16'd90;
        kind = 0;
      end else begin
        bc = ($urandom_range(0, 6) == 0) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(3, 16));
        case ($urandom_range(0, 19))
          0: sl = '0;
          1, 2: sl = 16'($urandom_range(0, 65535));
          3, 4: sl = 16'($urandom_range(49, 400));
          default: sl = 16'($urandom_range(1, 48));
        endcase
        kind = $urandom_range(0, 9);
      end
      nd = (bc < MIN_BLOCKS) ? MIN_BLOCKS - 1 : (bc > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF - 1 : bc - 1;
      sb = (sl + nd - 1) / nd;
      configure(bc, sl);
      if (phase_no == 4) hold_req <= 1'b1;
      if (sb > MAX_STRIPE_BYTES_DEF) begin
        repeat ($urandom_range(1, 4)) send_req(1'($urandom), 8'($urandom));
      end else begin
        if (sb > 64) kind = ($urandom_range(0, 1) == 0) ? 8 : 9;
        case (kind)
          6: begin
            k = (sl == 0) ? 0 : $urandom_range(0, sl - 1);
            fill(k);
            drain(nd * sb - k + sb + 1);
          end
          7: begin
            k = nd * sb - sl + sb + 1;
            fill(sl + $urandom_range(1, 3));
            drain(1);
            fill(1);
            drain(k - 1);
          end
          8: repeat ($urandom_range(5, 30)) send_req(1'($urandom), 8'($urandom));
          9: fill($urandom_range(0, (sl < 60) ? sl : 60));
          default: begin
            fill(sl);
            drain(nd * sb - sl + sb + $urandom_range(0, 2));
          end
        endcase
      end
    end

    // largest legal segment, abandoned after a few bytes
    configure(5'd16, 16'd61440);
    fill(24);
    // one byte past the largest stripe
    configure(5'd3, 16'd8193);
    send_req(CMD_DATA, 8'hFF);
    send_req(CMD_DRAIN, 8'h00);
    // largest stripe on two data blocks, early drain of the first block
    configure(5'd3, 16'd8192);
    fill(5);
    drain(40);

    wait_drained();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/r5spe_pkg.sv
src/r5spe_ram.sv
src/raid5_stripe_parity_encoder_top.sv
tb/sv/r5spe_stripe_check.sv
tb/sv/tb.sv
